// ===== design/pirate_mmc3_bank_mapper_macros.svh =====
// Assertion helpers for the bank mapper. The enclosing scope must provide
// clk_i and rst_ni.
`ifndef PIRATE_MMC3_BANK_MAPPER_MACROS_SVH
`define PIRATE_MMC3_BANK_MAPPER_MACROS_SVH

// Same-cycle implication
`define PMMC3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbl failed");

// Next-cycle implication
`define PMMC3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbl failed");

`endif

// ===== design/pmmc3_pkg.sv =====
package pmmc3_pkg;

  // Request kinds
  typedef enum logic [2:0] {
    REQ_WRITE    = 3'd0,
    REQ_CPU_READ = 3'd1,
    REQ_PPU_READ = 3'd2,
    REQ_TICK     = 3'd3,
    REQ_INIT     = 3'd4
  } req_type_e;

  // Config port
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ROM_COUNT = 2'd0;
  localparam logic [7:0] ROM_COUNT_RESET = 8'd16;

  // Decoded bus write addresses
  localparam logic [15:0] ADDR_PRG_MODE    = 16'h5000;
  localparam logic [15:0] ADDR_SELECT      = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
  localparam logic [15:0] ADDR_SPECIAL_SEL = 16'h8003;
  localparam logic [15:0] ADDR_MIRROR      = 16'hA000;
  localparam logic [15:0] ADDR_IRQ_LOAD    = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_ACK     = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF_A   = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON_A    = 16'hE001;
  localparam logic [15:0] ADDR_IRQ_OFF_B   = 16'hE002;
  localparam logic [15:0] ADDR_IRQ_ON_B    = 16'hE003;

  // Special select patches
  localparam logic [7:0] SEL_PATCH_PRG1  = 8'h2A;
  localparam logic [7:0] SEL_PATCH_PRG2  = 8'h28;
  localparam logic [7:0] PATCH_PAGE_PRG1 = 8'h0F;
  localparam logic [7:0] PATCH_PAGE_PRG2 = 8'h17;

  // Security bytes
  localparam logic [7:0] SEC_BYTE_LOW = 8'h83;
  localparam logic [7:0] SEC_BYTE_MID = 8'h42;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] address;
    logic [7:0]  value;
    logic        in_vblank;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [21:0] rom_address;
    logic        irq_line;
    logic        mirror_horizontal;
  } res_t;

  // Fixed page counted back from the end of PRG ROM, modulo 256
  function automatic logic [7:0] fixed_page(input logic [7:0] count,
                                            input logic [2:0] back);
    return {count[6:0], 1'b0} - {5'd0, back};
  endfunction

endpackage

// ===== design/pmmc3_apb.sv =====
module pmmc3_apb (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pmmc3_pkg::PADDR_W-1:0] paddr,
  input  logic [pmmc3_pkg::PDATA_W-1:0] pwdata,
  output logic [pmmc3_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output logic [7:0]                   rom_count_o
);
  import pmmc3_pkg::*;

  logic [7:0] rom_count_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == REG_ROM_COUNT);

  // ROM size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_count_q <= ROM_COUNT_RESET;
    end else if (wr_en) begin
      rom_count_q <= pwdata[7:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr == REG_ROM_COUNT) begin
      prdata = {{(PDATA_W-8){1'b0}}, rom_count_q};
    end
  end

  assign rom_count_o = rom_count_q;

endmodule

// ===== design/pmmc3_core.sv =====
module pmmc3_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  pmmc3_pkg::req_t     req_i,
  input  logic [7:0]          rom_count_i,
  output pmmc3_pkg::res_t     res_o
);
  import pmmc3_pkg::*;

  logic [8:0] chr_q [8];
  logic [8:0] chr_d [8];
  logic [7:0] prg_q [4];
  logic [7:0] prg_d [4];
  logic [7:0] raw6_q, raw6_d, raw7_q, raw7_d;
  logic [1:0] ext_q, ext_d;          // extended mode bits 7 and 5
  logic [7:0] sel_q, sel_d;
  logic       special_q, special_d;
  logic       irq_en_q, irq_en_d;
  logic [7:0] irq_cnt_q, irq_cnt_d;
  logic       irq_pend_q, irq_pend_d;
  logic [7:0] last_q, last_d;
  logic       mirror_q, mirror_d;

  logic [15:0] addr;
  logic [7:0]  v;
  logic [7:0]  v_even;
  logic        prg_locked;
  logic [2:0]  chr_slot;

  assign addr       = req_i.address;
  assign v          = req_i.value;
  assign v_even     = {v[7:1], 1'b0};
  assign prg_locked = ext_q == 2'b11;
  assign chr_slot   = addr[12:10];

  // Next state
  always_comb begin
    chr_d      = chr_q;
    prg_d      = prg_q;
    raw6_d     = raw6_q;
    raw7_d     = raw7_q;
    ext_d      = ext_q;
    sel_d      = sel_q;
    special_d  = special_q;
    irq_en_d   = irq_en_q;
    irq_cnt_d  = irq_cnt_q;
    irq_pend_d = irq_pend_q;
    last_d     = last_q;
    mirror_d   = mirror_q;
    case (req_i.req_type)
      REQ_WRITE: begin
        if (addr[15:12] == 4'h5) begin
          last_d = v;
          if (addr == ADDR_PRG_MODE) begin
            ext_d = {v[7], v[5]};
            if (v[7]) begin
              if (v[5]) begin
                for (int i = 0; i < 4; i++) begin
                  prg_d[i] = {2'b00, v[4:1], 2'(i)};
                end
              end else begin
                prg_d[2] = {2'b00, v[4:0], 1'b0};
                prg_d[3] = {2'b00, v[4:0], 1'b1};
              end
            end else begin
              prg_d[0] = raw6_q;
              prg_d[1] = raw7_q;
              prg_d[2] = fixed_page(rom_count_i, 3'd2);
              prg_d[3] = fixed_page(rom_count_i, 3'd1);
            end
          end
        end else if (addr[15]) begin
          last_d = v;
          case (addr)
            ADDR_SPECIAL_SEL: begin
              special_d = 1'b1;
              sel_d     = v;
              if (v[7:4] == 4'h0) begin
                prg_d[2] = fixed_page(rom_count_i, 3'd2);
              end
            end
            ADDR_SELECT: begin
              special_d = 1'b0;
              sel_d     = v;
            end
            ADDR_BANK_DATA: begin
              if (!special_q) begin
                case (sel_q[2:0])
                  3'd0: begin
                    chr_d[4] = {1'b1, v_even};
                    chr_d[5] = {1'b1, v_even[7:1], 1'b1};
                  end
                  3'd1: begin
                    chr_d[6] = {1'b1, v_even};
                    chr_d[7] = {1'b1, v_even[7:1], 1'b1};
                  end
                  3'd2: chr_d[0] = {1'b0, v};
                  3'd3: chr_d[1] = {1'b0, v};
                  3'd4: chr_d[2] = {1'b0, v};
                  3'd5: chr_d[3] = {1'b0, v};
                  3'd6: if (!prg_locked) prg_d[0] = v;
                  default: if (!prg_locked) prg_d[1] = v;
                endcase
              end else if (sel_q == SEL_PATCH_PRG1) begin
                prg_d[1] = PATCH_PAGE_PRG1;
              end else if (sel_q == SEL_PATCH_PRG2) begin
                prg_d[2] = PATCH_PAGE_PRG2;
              end
              // only raw slots 6 and 7 are ever read back
              if (sel_q[2:0] == 3'd6) raw6_d = v;
              if (sel_q[2:0] == 3'd7) raw7_d = v;
            end
            ADDR_MIRROR: mirror_d = v[0];
            ADDR_IRQ_LOAD: begin
              irq_cnt_d  = v;
              irq_pend_d = 1'b0;
            end
            ADDR_IRQ_ACK: irq_pend_d = 1'b0;
            ADDR_IRQ_OFF_A, ADDR_IRQ_OFF_B: begin
              irq_en_d   = 1'b0;
              irq_pend_d = 1'b0;
            end
            ADDR_IRQ_ON_A, ADDR_IRQ_ON_B: begin
              irq_en_d   = 1'b1;
              irq_pend_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      REQ_TICK: begin
        if (!req_i.in_vblank && irq_en_q) begin
          if (irq_cnt_q == 8'd0) begin
            irq_en_d   = 1'b0;
            irq_pend_d = 1'b1;
          end
          irq_cnt_d = irq_cnt_q - 8'd1;
        end
      end
      REQ_INIT: begin
        for (int i = 0; i < 8; i++) begin
          chr_d[i] = '0;
        end
        for (int i = 0; i < 4; i++) begin
          prg_d[i] = fixed_page(rom_count_i, 3'(4 - i));
        end
        raw6_d     = '0;
        raw7_d     = '0;
        ext_d      = '0;
        sel_d      = '0;
        special_d  = 1'b0;
        irq_en_d   = 1'b0;
        irq_cnt_d  = '0;
        irq_pend_d = 1'b0;
        last_d     = '0;
      end
      default: ;
    endcase
  end

  // Result word: reads see state before the step, flags after it
  always_comb begin
    res_o                   = '0;
    res_o.irq_line          = irq_pend_d;
    res_o.mirror_horizontal = mirror_d;
    case (req_i.req_type)
      REQ_CPU_READ: begin
        if (addr[15:12] == 4'h5) begin
          case (last_q[1:0])
            2'd0, 2'd1: res_o.read_data = SEC_BYTE_LOW;
            2'd2:       res_o.read_data = SEC_BYTE_MID;
            default:    res_o.read_data = '0;
          endcase
        end else if (addr[15]) begin
          res_o.rom_address = {1'b0, prg_q[addr[14:13]], addr[12:0]};
        end
      end
      REQ_PPU_READ: begin
        if (addr[15:13] == 3'd0) begin
          res_o.rom_address = {chr_q[chr_slot], chr_slot, addr[9:0]};
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chr_q[i] <= '0;
      end
      for (int i = 0; i < 4; i++) begin
        prg_q[i] <= fixed_page(ROM_COUNT_RESET, 3'(4 - i));
      end
      raw6_q     <= '0;
      raw7_q     <= '0;
      ext_q      <= '0;
      sel_q      <= '0;
      special_q  <= 1'b0;
      irq_en_q   <= 1'b0;
      irq_cnt_q  <= '0;
      irq_pend_q <= 1'b0;
      last_q     <= '0;
      mirror_q   <= 1'b0;
    end else if (fire_i) begin
      chr_q      <= chr_d;
      prg_q      <= prg_d;
      raw6_q     <= raw6_d;
      raw7_q     <= raw7_d;
      ext_q      <= ext_d;
      sel_q      <= sel_d;
      special_q  <= special_d;
      irq_en_q   <= irq_en_d;
      irq_cnt_q  <= irq_cnt_d;
      irq_pend_q <= irq_pend_d;
      last_q     <= last_d;
      mirror_q   <= mirror_d;
    end
  end

endmodule

// ===== design/pirate_mmc3_bank_mapper.sv =====
// Channel  Handshake                 Words
// request  in_valid_i/in_ready_o     req_type_i address_i value_i in_vblank_i
// result   out_valid_o/out_ready_i   read_data_o rom_address_o irq_line_o mirror_horizontal_o
// config   psel/penable/pwrite/pready  paddr pwdata prdata
//
// One word per cycle sustained while out_ready_i stays high; a request passes
// the input register, then mapper state update and the result register.
// Reset (rst_ni low) restores all mapper state and the ROM size register at once.
// A stalled result holds in the output register while one more request waits
// in the input register; after that in_ready_o drops.
`include "pirate_mmc3_bank_mapper_macros.svh"

module pirate_mmc3_bank_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    req_type_i,
  input  logic [15:0]                   address_i,
  input  logic [7:0]                    value_i,
  input  logic                          in_vblank_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    read_data_o,
  output logic [21:0]                   rom_address_o,
  output logic                          irq_line_o,
  output logic                          mirror_horizontal_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmmc3_pkg::PADDR_W-1:0] paddr,
  input  logic [pmmc3_pkg::PDATA_W-1:0] pwdata,
  output logic [pmmc3_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import pmmc3_pkg::*;

  logic       in_vld_q;
  req_t       in_q;
  logic       out_vld_q;
  res_t       out_q;
  res_t       res_d;
  logic       advance;
  logic [7:0] rom_count;
  logic       out_blank;

  pmmc3_apb u_apb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .rom_count_o (rom_count)
  );

  // Word moves from input to output register
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= '{req_type: req_type_i, address: address_i, value: value_i,
                in_vblank: in_vblank_i};
    end
  end

  pmmc3_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .req_i       (in_q),
    .rom_count_i (rom_count),
    .res_o       (res_d)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign read_data_o         = out_q.read_data;
  assign rom_address_o       = out_q.rom_address;
  assign irq_line_o          = out_q.irq_line;
  assign mirror_horizontal_o = out_q.mirror_horizontal;

  // Checks
  assign out_blank = (out_q.read_data == 8'd0) && (out_q.rom_address == 22'd0);

  `PMMC3_ASSERT_NOW(a_full_blocks_input, in_vld_q && out_vld_q && !out_ready_i, !in_ready_o)
  `PMMC3_ASSERT_NEXT(a_advance_fills_output, advance, out_vld_q)
  `PMMC3_ASSERT_NEXT(a_write_has_no_data, advance && in_q.req_type == REQ_WRITE, out_blank)

endmodule
